// ===== rtl/odr_pkg.sv =====
// Shared types, constants and helper functions for the odometry dead reckoning block.
`default_nettype none
package odr_pkg;

    // CORDIC iteration count, capped at the length of the arctangent table
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_COUNT   = 24;
    localparam int NUM_ITER     = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
    localparam int ITER_W       = 5;

    // datapath widths
    localparam int CW      = 38;     // CORDIC x/y
    localparam int ZW      = 34;     // CORDIC angle, 2^32 = full turn
    localparam int MOP_W   = 38;     // multiplier operand
    localparam int K_W     = 30;     // inverse gain constant
    localparam int PROD_W  = MOP_W + K_W;
    localparam int KCNT_W  = 5;

    localparam logic [K_W-1:0] GAIN_INV = 30'h26DD3B6A;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VEC,
        ST_MUL_LEN,
        ST_MUL_ROT,
        ST_ROT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        REG_START_X       = 2'd0,
        REG_START_Y       = 2'd1,
        REG_START_HEADING = 2'd2
    } cfg_reg_t;

    // arctangent of 2^-i, 2^32 = full turn
    function automatic logic [31:0] atan_lookup(input logic [ITER_W-1:0] idx);
        logic [31:0] r;
        begin
            case (idx)
                5'd0:    r = 32'h20000000;
                5'd1:    r = 32'h12E4051E;
                5'd2:    r = 32'h09FB385B;
                5'd3:    r = 32'h051111D4;
                5'd4:    r = 32'h028B0D43;
                5'd5:    r = 32'h0145D7E1;
                5'd6:    r = 32'h00A2F61E;
                5'd7:    r = 32'h00517C55;
                5'd8:    r = 32'h0028BE53;
                5'd9:    r = 32'h00145F2F;
                5'd10:   r = 32'h000A2F98;
                5'd11:   r = 32'h000517CC;
                5'd12:   r = 32'h00028BE6;
                5'd13:   r = 32'h000145F3;
                5'd14:   r = 32'h0000A2FA;
                5'd15:   r = 32'h0000517D;
                5'd16:   r = 32'h000028BE;
                5'd17:   r = 32'h0000145F;
                5'd18:   r = 32'h00000A30;
                5'd19:   r = 32'h00000518;
                5'd20:   r = 32'h0000028C;
                5'd21:   r = 32'h00000146;
                5'd22:   r = 32'h000000A3;
                5'd23:   r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    // saturate a 39 bit signed sum to 32 bit signed
    function automatic logic signed [31:0] sat32(input logic signed [CW:0] v);
        logic signed [31:0] r;
        begin
            if (!v[CW] && (|v[CW-1:31]))
                r = 32'sh7FFFFFFF;
            else if (v[CW] && !(&v[CW-1:31]))
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/odr_cordic_step.sv =====
// One shared CORDIC micro-rotation, used for both vectoring and rotation.
`default_nettype none
module odr_cordic_step (
    input  wire logic                            vec_mode,
    input  wire logic [odr_pkg::ITER_W-1:0]      iter,
    input  wire logic signed [odr_pkg::CW-1:0]   x_in,
    input  wire logic signed [odr_pkg::CW-1:0]   y_in,
    input  wire logic signed [odr_pkg::ZW-1:0]   z_in,
    output logic signed [odr_pkg::CW-1:0]        x_out,
    output logic signed [odr_pkg::CW-1:0]        y_out,
    output logic signed [odr_pkg::ZW-1:0]        z_out
);

    logic signed [odr_pkg::CW-1:0] xs;
    logic signed [odr_pkg::CW-1:0] ys;
    logic signed [odr_pkg::ZW-1:0] at;
    logic                          dir_neg;

    // direction: drive y to zero when vectoring, z to zero when rotating
    always_comb
    begin
        xs      = x_in >>> iter;
        ys      = y_in >>> iter;
        at      = signed'({2'b00, odr_pkg::atan_lookup(iter)});
        dir_neg = vec_mode ? ~y_in[odr_pkg::CW-1] : z_in[odr_pkg::ZW-1];
        if (dir_neg)
        begin
            x_out = x_in + ys;
            y_out = y_in - xs;
            z_out = z_in + at;
        end
        else
        begin
            x_out = x_in - ys;
            y_out = y_in + xs;
            z_out = z_in - at;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/odr_mulk.sv =====
// Shift-and-add multiplier by the inverse CORDIC gain, one constant bit per cycle, rounded.
`default_nettype none
module odr_mulk (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [odr_pkg::MOP_W-1:0]     operand,
    output logic                               done,
    output logic [odr_pkg::PROD_W-1:0]         product
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [odr_pkg::KCNT_W-1:0]      cnt_reg, cnt_next;
    logic [odr_pkg::PROD_W-1:0]      sh_reg, sh_next;
    logic [odr_pkg::PROD_W-1:0]      acc_reg, acc_next;

    // one partial product per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            sh_next   = odr_pkg::PROD_W'(operand);
            acc_next  = odr_pkg::PROD_W'(1) << 29;
        end
        else if (busy_reg)
        begin
            if (odr_pkg::GAIN_INV[cnt_reg])
                acc_next = acc_reg + sh_reg;
            sh_next  = sh_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == odr_pkg::KCNT_W'(odr_pkg::K_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
`default_nettype wire

// ===== rtl/odometry_dead_reckoning_unit.sv =====
// Top level of the odometry dead reckoning unit: sequencer, pose state and result register.
//
// Usage: raw odometry beats (odom_x, odom_y, odom_heading) enter on the in channel
// (in_valid/in_ready); each beat yields exactly one integrated pose beat on the out
// channel (out_valid/out_ready). The user writes the start pose through cfg_we/
// cfg_index/cfg_data while idle; the block does not enforce this. The start pose
// takes effect at the first beat after reset. The first beat after reset answers
// with the start pose and step length 0. Every later beat passes through the accept
// cycle, 16 CORDIC vectoring iterations, two serial multiplications by the inverse
// gain, 16 CORDIC rotation iterations and the write-back state. The single shared
// CORDIC stage and bit-serial constant multiplier serialise this; in_ready stays low until idle.
// A finished pose sits in an output register; the next input beat is taken while it
// waits. If the receiver stalls, the following pose holds in the sequencer until the
// output register is free.
// Reset clears the pose state and the started flag and loads the default start pose.
`default_nettype none
module odometry_dead_reckoning_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] odom_x,
    input  wire logic signed [31:0] odom_y,
    input  wire logic signed [15:0] odom_heading,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      est_x,
    output logic signed [31:0]      est_y,
    output logic signed [15:0]      est_heading,
    output logic [31:0]             step_length
);

    localparam int CW = odr_pkg::CW;
    localparam int ZW = odr_pkg::ZW;

    odr_pkg::state_t state_reg, state_next;

    logic signed [31:0] start_x_reg, start_y_reg;
    logic signed [15:0] start_heading_reg;
    logic signed [31:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic signed [15:0] prev_heading_reg, prev_heading_next;
    logic signed [31:0] acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;
    logic signed [15:0] acc_heading_reg, acc_heading_next;
    logic               started_reg, started_next;
    logic signed [CW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ZW-1:0] cz_reg, cz_next;
    logic [odr_pkg::ITER_W-1:0] iter_reg, iter_next;
    logic [31:0]        len_reg, len_next;
    logic signed [31:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic signed [15:0] out_h_reg, out_h_next;
    logic [31:0]        out_len_reg, out_len_next;
    logic               out_valid_reg, out_valid_next;

    logic               in_fire;
    logic               last_iter;
    logic               out_free;
    logic               step_vec;
    logic signed [CW-1:0] sx, sy;
    logic signed [ZW-1:0] sz;
    logic               mul_start, mul_done;
    logic [odr_pkg::MOP_W-1:0]  mul_op;
    logic [odr_pkg::PROD_W-1:0] mul_prod;

    logic signed [32:0] dx, dy;
    logic signed [ZW-1:0] z_full;
    logic signed [CW:0]   sum_x, sum_y;
    logic [odr_pkg::MOP_W-1:0] vec_len_q;
    logic [31:0]        len_sat;

    assign in_ready  = (state_reg == odr_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign last_iter = (iter_reg == odr_pkg::ITER_W'(odr_pkg::NUM_ITER - 1));
    assign out_free  = !out_valid_reg || out_ready;
    assign step_vec  = (state_reg == odr_pkg::ST_VEC);

    odr_cordic_step u_step (
        .vec_mode (step_vec),
        .iter     (iter_reg),
        .x_in     (cx_reg),
        .y_in     (cy_reg),
        .z_in     (cz_reg),
        .x_out    (sx),
        .y_out    (sy),
        .z_out    (sz)
    );

    odr_mulk u_mulk (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (mul_op),
        .done    (mul_done),
        .product (mul_prod)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            odr_pkg::ST_IDLE:
                if (in_fire)
                    state_next = started_reg ? odr_pkg::ST_VEC : odr_pkg::ST_DONE;
            odr_pkg::ST_VEC:
                if (last_iter)
                    state_next = odr_pkg::ST_MUL_LEN;
            odr_pkg::ST_MUL_LEN:
                if (mul_done)
                    state_next = odr_pkg::ST_MUL_ROT;
            odr_pkg::ST_MUL_ROT:
                if (mul_done)
                    state_next = odr_pkg::ST_ROT;
            odr_pkg::ST_ROT:
                if (last_iter)
                    state_next = odr_pkg::ST_DONE;
            odr_pkg::ST_DONE:
                if (out_free)
                    state_next = odr_pkg::ST_IDLE;
            default:
                state_next = odr_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        prev_x_next       = prev_x_reg;
        prev_y_next       = prev_y_reg;
        prev_heading_next = prev_heading_reg;
        acc_x_next        = acc_x_reg;
        acc_y_next        = acc_y_reg;
        acc_heading_next  = acc_heading_reg;
        started_next      = started_reg;
        cx_next           = cx_reg;
        cy_next           = cy_reg;
        cz_next           = cz_reg;
        iter_next         = iter_reg;
        len_next          = len_reg;
        out_x_next        = out_x_reg;
        out_y_next        = out_y_reg;
        out_h_next        = out_h_reg;
        out_len_next      = out_len_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        mul_start         = 1'b0;
        mul_op            = '0;

        dx        = 33'(odom_x) - 33'(prev_x_reg);
        dy        = 33'(odom_y) - 33'(prev_y_reg);
        z_full    = signed'({{(ZW-32){acc_heading_reg[15]}}, acc_heading_reg, 16'h0000});
        sum_x     = (CW+1)'(acc_x_reg) + (CW+1)'(cx_reg);
        sum_y     = (CW+1)'(acc_y_reg) + (CW+1)'(cy_reg);
        vec_len_q = mul_prod[odr_pkg::PROD_W-1:30];
        len_sat   = (|vec_len_q[odr_pkg::MOP_W-1:32]) ? 32'hFFFFFFFF : vec_len_q[31:0];

        unique case (state_reg)
            odr_pkg::ST_IDLE:
                if (in_fire)
                begin
                    prev_x_next       = odom_x;
                    prev_y_next       = odom_y;
                    prev_heading_next = odom_heading;
                    iter_next         = '0;
                    if (!started_reg)
                    begin
                        // first beat: answer with the start pose
                        started_next     = 1'b1;
                        acc_x_next       = start_x_reg;
                        acc_y_next       = start_y_reg;
                        acc_heading_next = start_heading_reg;
                        cx_next          = '0;
                        cy_next          = '0;
                        len_next         = '0;
                    end
                    else
                    begin
                        cx_next          = dx[32] ? -CW'(dx) : CW'(dx);
                        cy_next          = dy[32] ? -CW'(dy) : CW'(dy);
                        cz_next          = z_full;
                        acc_heading_next = acc_heading_reg + (odom_heading - prev_heading_reg);
                    end
                end
            odr_pkg::ST_VEC:
            begin
                cx_next   = sx;
                cy_next   = sy;
                iter_next = iter_reg + 1'b1;
                if (last_iter)
                begin
                    mul_start = 1'b1;
                    mul_op    = sx[CW-1] ? '0 : odr_pkg::MOP_W'(unsigned'(sx));
                end
            end
            odr_pkg::ST_MUL_LEN:
                if (mul_done)
                begin
                    len_next  = len_sat;
                    mul_start = 1'b1;
                    mul_op    = odr_pkg::MOP_W'(len_sat);
                end
            odr_pkg::ST_MUL_ROT:
                if (mul_done)
                begin
                    // fold the heading into +-quarter turn, negating the vector
                    cy_next   = '0;
                    iter_next = '0;
                    if (cz_reg > 34'sh040000000 || cz_reg < -34'sh040000000)
                    begin
                        cx_next = -signed'(CW'(mul_prod[61:30]));
                        cz_next = cz_reg[ZW-1] ? cz_reg + 34'sh080000000
                                               : cz_reg - 34'sh080000000;
                    end
                    else
                    begin
                        cx_next = signed'(CW'(mul_prod[61:30]));
                    end
                end
            odr_pkg::ST_ROT:
            begin
                cx_next   = sx;
                cy_next   = sy;
                cz_next   = sz;
                iter_next = iter_reg + 1'b1;
            end
            odr_pkg::ST_DONE:
                if (out_free)
                begin
                    acc_x_next     = odr_pkg::sat32(sum_x);
                    acc_y_next     = odr_pkg::sat32(sum_y);
                    out_x_next     = odr_pkg::sat32(sum_x);
                    out_y_next     = odr_pkg::sat32(sum_y);
                    out_h_next     = acc_heading_reg;
                    out_len_next   = len_reg;
                    out_valid_next = 1'b1;
                end
            default:
            begin
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg       <= -32'sd65536;
            start_y_reg       <= 32'sd65536;
            start_heading_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                odr_pkg::REG_START_X:       start_x_reg       <= signed'(cfg_data);
                odr_pkg::REG_START_Y:       start_y_reg       <= signed'(cfg_data);
                odr_pkg::REG_START_HEADING: start_heading_reg <= signed'(cfg_data[15:0]);
                default:
                begin
                end
            endcase
        end
    end

    // control and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= odr_pkg::ST_IDLE;
            started_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            iter_reg         <= '0;
            prev_x_reg       <= '0;
            prev_y_reg       <= '0;
            prev_heading_reg <= '0;
            acc_x_reg        <= '0;
            acc_y_reg        <= '0;
            acc_heading_reg  <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            started_reg      <= started_next;
            out_valid_reg    <= out_valid_next;
            iter_reg         <= iter_next;
            prev_x_reg       <= prev_x_next;
            prev_y_reg       <= prev_y_next;
            prev_heading_reg <= prev_heading_next;
            acc_x_reg        <= acc_x_next;
            acc_y_reg        <= acc_y_next;
            acc_heading_reg  <= acc_heading_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        cz_reg      <= cz_next;
        len_reg     <= len_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        out_h_reg   <= out_h_next;
        out_len_reg <= out_len_next;
    end

    assign out_valid   = out_valid_reg;
    assign est_x       = out_x_reg;
    assign est_y       = out_y_reg;
    assign est_heading = out_h_reg;
    assign step_length = out_len_reg;

`ifndef SYNTHESIS
    // an accepted beat makes the block busy at once
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready stayed high after an accepted beat");

    // a new result is only loaded from the write-back state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == odr_pkg::ST_DONE))
        else $error("result appeared outside write-back");

    // multiplier completion only while the sequencer waits for it
    a_mul_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == odr_pkg::ST_MUL_LEN || state_reg == odr_pkg::ST_MUL_ROT))
        else $error("multiplier finished in an unexpected state");
`endif

endmodule
`default_nettype wire

// ===== verif/odometry_dead_reckoning_checker.sv =====
// Pose predictor and scoreboard for the odometry dead reckoning unit.
module odometry_dead_reckoning_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic signed [31:0] odom_x,
    input  wire logic signed [31:0] odom_y,
    input  wire logic signed [15:0] odom_heading,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic signed [31:0] est_x,
    input  wire logic signed [31:0] est_y,
    input  wire logic signed [15:0] est_heading,
    input  wire logic [31:0]        step_length,
    output int                      fail_count,
    output int                      pending,
    output int                      checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] heading;
        logic [31:0]        len;
    } pose_t;

    localparam longint GAIN_K = 64'h26DD3B6A;
    localparam longint ROUND_HALF = 64'sd1 << 29;

    // arctangent of 2^-i, 2^32 per turn
    localparam longint ARCTAN [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    // start pose registers and integration state
    logic signed [31:0] start_x, start_y;
    logic signed [15:0] start_heading;
    logic signed [31:0] last_x, last_y;
    logic signed [15:0] last_heading;
    logic signed [31:0] pose_x, pose_y;
    logic signed [15:0] pose_heading;
    logic               seen_first;
    pose_t              pose_queue[$];

    // vectoring pass: magnitude of the step, gain corrected, saturated
    function automatic logic [31:0] step_magnitude(longint dx, longint dy);
        longint vx, vy, nx, ny, m;
        vx = (dx < 0) ? -dx : dx;
        vy = (dy < 0) ? -dy : dy;
        for (int i = 0; i < odr_pkg::NUM_ITER; i++)
        begin
            if (vy >= 0)
            begin
                nx = vx + (vy >>> i);
                ny = vy - (vx >>> i);
            end
            else
            begin
                nx = vx - (vy >>> i);
                ny = vy + (vx >>> i);
            end
            vx = nx;
            vy = ny;
        end
        if (vx < 0)
            vx = 0;
        m = (vx * GAIN_K + ROUND_HALF) >>> 30;
        if (m > 64'sh0FFFFFFFF)
            return 32'hFFFFFFFF;
        return m[31:0];
    endfunction

    // rotation pass: turn (len, 0) by the heading
    function automatic void turn_step(logic [31:0] len, logic signed [15:0] hd,
                                      output longint ox, output longint oy);
        longint vx, vy, z, nx, ny;
        vx = ({32'd0, len} * GAIN_K + ROUND_HALF) >>> 30;
        vy = 0;
        z  = longint'(hd) * 65536;
        if (z > (64'sd1 <<< 30))
        begin
            z  = z - (64'sd1 <<< 31);
            vx = -vx;
        end
        else if (z < -(64'sd1 <<< 30))
        begin
            z  = z + (64'sd1 <<< 31);
            vx = -vx;
        end
        for (int i = 0; i < odr_pkg::NUM_ITER; i++)
        begin
            if (z >= 0)
            begin
                nx = vx - (vy >>> i);
                ny = vy + (vx >>> i);
                z  = z - ARCTAN[i];
            end
            else
            begin
                nx = vx + (vy >>> i);
                ny = vy - (vx >>> i);
                z  = z + ARCTAN[i];
            end
            vx = nx;
            vy = ny;
        end
        ox = vx;
        oy = vy;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // one odometry beat in, one expected pose out
    task automatic integrate_beat(logic signed [31:0] ix, logic signed [31:0] iy,
                                  logic signed [15:0] ih);
        pose_t  p;
        longint mx, my;
        logic [15:0] dh;
        p.len = '0;
        if (!seen_first)
        begin
            seen_first   = 1'b1;
            pose_x       = start_x;
            pose_y       = start_y;
            pose_heading = start_heading;
        end
        else
        begin
            p.len = step_magnitude(longint'(ix) - longint'(last_x),
                                   longint'(iy) - longint'(last_y));
            turn_step(p.len, pose_heading, mx, my);
            pose_x       = clamp32(longint'(pose_x) + mx);
            pose_y       = clamp32(longint'(pose_y) + my);
            dh           = ih - last_heading;
            pose_heading = pose_heading + dh;
        end
        last_x       = ix;
        last_y       = iy;
        last_heading = ih;
        p.x       = pose_x;
        p.y       = pose_y;
        p.heading = pose_heading;
        pose_queue = {pose_queue, p};
    endtask

    task automatic compare_pose();
        pose_t e;
        if (pose_queue.size() == 0)
        begin
            $display("%0t: pose beat with none expected: x=%0d y=%0d h=%0d len=%0d",
                     $time, est_x, est_y, est_heading, step_length);
            fail_count++;
            return;
        end
        e = pose_queue.pop_front();
        checked++;
        if (est_x !== e.x)
        begin
            $display("%0t: est_x expected %0d actual %0d", $time, e.x, est_x);
            fail_count++;
        end
        if (est_y !== e.y)
        begin
            $display("%0t: est_y expected %0d actual %0d", $time, e.y, est_y);
            fail_count++;
        end
        if (est_heading !== e.heading)
        begin
            $display("%0t: est_heading expected %0d actual %0d", $time, e.heading,
                     est_heading);
            fail_count++;
        end
        if (step_length !== e.len)
        begin
            $display("%0t: step_length expected %0d actual %0d", $time, e.len,
                     step_length);
            fail_count++;
        end
    endtask

    // watch the channels at every rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x       = -32'sd65536;
            start_y       = 32'sd65536;
            start_heading = '0;
            last_x        = '0;
            last_y        = '0;
            last_heading  = '0;
            pose_x        = '0;
            pose_y        = '0;
            pose_heading  = '0;
            seen_first    = 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    odr_pkg::REG_START_X:       start_x = cfg_data;
                    odr_pkg::REG_START_Y:       start_y = cfg_data;
                    odr_pkg::REG_START_HEADING: start_heading = cfg_data[15:0];
                    default:                    ;
                endcase
            end
            if (in_valid && in_ready)
                integrate_beat(odom_x, odom_y, odom_heading);
            if (out_valid && out_ready)
                compare_pose();
        end
    end

    initial
    begin
        fail_count = 0;
        checked    = 0;
    end

    assign pending = pose_queue.size();

endmodule

// ===== verif/odometry_dead_reckoning_unit_test.sv =====
// Stimulus, reset, watchdog and verdict for the odometry dead reckoning unit.
module odometry_dead_reckoning_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 4000;
    // register index past the end of the list, written to check it is ignored
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] odom_x;
    logic signed [31:0] odom_y;
    logic signed [15:0] odom_heading;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic signed [15:0] est_heading;
    logic [31:0]        step_length;
    int                 fail_count;
    int                 pending;
    int                 checked;
    int                 beats_sent;
    int                 burst_left;
    int                 idle_cycles;
    logic signed [31:0] cur_x, cur_y;
    logic signed [15:0] cur_h;

    odometry_dead_reckoning_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .odom_x(odom_x), .odom_y(odom_y), .odom_heading(odom_heading),
        .out_valid(out_valid), .out_ready(out_ready),
        .est_x(est_x), .est_y(est_y), .est_heading(est_heading),
        .step_length(step_length)
    );

    odometry_dead_reckoning_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .odom_x(odom_x), .odom_y(odom_y), .odom_heading(odom_heading),
        .out_valid(out_valid), .out_ready(out_ready),
        .est_x(est_x), .est_y(est_y), .est_heading(est_heading),
        .step_length(step_length),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired at %0t", $time);
            $display("FAIL");
            $finish;
        end
    end

    // receiver: switches between random stall modes, each held for a random run
    initial
    begin
        int mode;
        int left;
        out_ready = 1'b0;
        mode = 0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
                0:       out_ready = 1'b1;
                1:       out_ready = ($urandom_range(0, 1) == 1);
                2:       out_ready = ($urandom_range(0, 7) == 0);
                default: out_ready = ($urandom_range(0, 39) == 0) ? ~out_ready : out_ready;
            endcase
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // present one beat, hold until taken, then maybe close the burst
    task automatic send_beat(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [15:0] h);
        int gap;
        in_valid     = 1'b1;
        odom_x       = x;
        odom_y       = y;
        odom_heading = h;
        cur_x = x;
        cur_y = y;
        cur_h = h;
        // in_ready is steady between edges: look at it mid-cycle
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        beats_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 20);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    // wait until every pose is back, then a settle margin for the sequencer
    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2:       return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic signed [31:0] dx, dy;
        cfg_we       = 1'b0;
        cfg_index    = odr_pkg::REG_START_X;
        cfg_data     = '0;
        in_valid     = 1'b0;
        odom_x       = '0;
        odom_y       = '0;
        odom_heading = '0;
        beats_sent   = 0;
        burst_left   = 0;
        idle_cycles  = 0;
        rst_n        = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // start pose, taken up by the first beat
        write_reg(odr_pkg::REG_START_X, pick_extreme());
        write_reg(odr_pkg::REG_START_Y, pick_extreme());
        write_reg(odr_pkg::REG_START_HEADING, {16'h0, 16'(pick_extreme() >> 16)});
        write_reg(REG_UNUSED, $urandom);

        // directed: first sample, still, wrap of yaw, huge steps, saturation
        send_beat(32'sh12345678, -32'sd5000, 16'sh7FFF);
        send_beat(32'sh12345678, -32'sd5000, -16'sh8000);
        send_beat(32'sh12355678, -32'sd5000, 16'sh4000);
        send_beat(32'sh12355678, -32'sd3000, 16'sh4001);
        send_beat(32'sh12355678, -32'sd3000, -16'sh4001);
        send_beat(32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sh0);
        send_beat(32'sh80000000, 32'sh80000000, 16'sh7FFF);
        send_beat(32'sh7FFFFFFF, 32'sh80000000, -16'sh8000);
        send_beat(32'sh80000000, 32'sh7FFFFFFF, 16'sh2000);
        send_beat(32'sh7FFFFFFF, 32'sh7FFFFFFF, -16'sh2000);
        send_beat(32'sh80000000, 32'sh80000000, 16'sh0);
        send_beat(32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sh6000);
        send_beat(32'sh80000000, 32'sh80000000, -16'sh6000);
        send_beat(32'sh0, 32'sh0, 16'sh0);
        send_beat(32'sh10000, 32'sh0, 16'sh0);
        send_beat(32'sh10000, 32'sh10000, -16'sh7FFF);
        drain();

        // late writes leave the running estimate alone
        write_reg(odr_pkg::REG_START_X, 32'h80000000);
        write_reg(odr_pkg::REG_START_Y, 32'h7FFFFFFF);
        write_reg(odr_pkg::REG_START_HEADING, 32'h00008000);

        // random: mostly small motion, some wild jumps
        for (int n = 0; n < 500; n++)
        begin
            if (n == 250)
            begin
                drain();
                write_reg(odr_pkg::REG_START_X, pick_extreme());
                write_reg(odr_pkg::REG_START_Y, pick_extreme());
                write_reg(odr_pkg::REG_START_HEADING, $urandom);
                write_reg(REG_UNUSED, $urandom);
            end
            if ($urandom_range(0, 9) < 7)
            begin
                dx = $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
                dy = $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
                send_beat(cur_x + dx, cur_y + dy,
                          cur_h + 16'($signed($urandom_range(0, 2047)) - 1024));
            end
            else
                send_beat($urandom, $urandom, 16'($urandom));
        end
        drain();

        $display("%0d odometry beats sent, %0d poses checked, %0d mismatches",
                 beats_sent, checked, fail_count);
        $display("covered start pose extremes, yaw wrap, step and position saturation");
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
